/* rtl/ipd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types and constants of the pulse-distance IR frame decoder:
// register indexes, item action codes, status codes and the frame state.
// ----------------------------------------------------------------------------
package ipd_pkg;

  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned FRAME_W  = 32;
  localparam int unsigned POS_W    = 5;

  // intervals in a full frame: the start interval plus 32 bit intervals
  localparam logic [COUNT_W-1:0] FRAME_INTERVALS = 6'd33;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_ADDR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASK   = 3'd7;

  localparam logic [BYTE_W-1:0] INV_MASK_RESET = 8'hFF;

  // input item actions
  localparam logic ACT_EDGE    = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INCOMPLETE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_START    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_BIT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ADDR_INV     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ADDR_MISMATCH = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CMD_INV      = 3'd6;

  typedef struct packed {
    logic                 start_ok;
    logic                 bit_error;
    logic [COUNT_W-1:0]   count;
    logic [FRAME_W-1:0]   bits;
  } ipd_frame_t;

endpackage

/* rtl/ipd_status.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_status
// Frame verdict: checks length, start interval, bit errors, the address
// inversion byte, the expected address and the command inversion byte, in priority order, and yields the status code.
// ----------------------------------------------------------------------------
module ipd_status (
  input  ipd_pkg::ipd_frame_t                 frame_i,
  input  logic [ipd_pkg::BYTE_W-1:0]          exp_addr_i,
  input  logic [ipd_pkg::BYTE_W-1:0]          inv_mask_i,
  output logic [ipd_pkg::STATUS_W-1:0]        status_o
);
  import ipd_pkg::*;

  logic [BYTE_W-1:0] addr;
  logic [BYTE_W-1:0] addr_inv;
  logic [BYTE_W-1:0] cmd;
  logic [BYTE_W-1:0] cmd_inv;

  assign addr     = frame_i.bits[7:0];
  assign addr_inv = frame_i.bits[15:8];
  assign cmd      = frame_i.bits[23:16];
  assign cmd_inv  = frame_i.bits[31:24];

  always_comb begin
    if (frame_i.count < FRAME_INTERVALS) begin
      status_o = ST_INCOMPLETE;
    end else if (!frame_i.start_ok) begin
      status_o = ST_BAD_START;
    end else if (frame_i.bit_error) begin
      status_o = ST_BAD_BIT;
    end else if ((addr_inv ^ inv_mask_i) != addr) begin
      status_o = ST_ADDR_INV;
    end else if (addr != exp_addr_i) begin
      status_o = ST_ADDR_MISMATCH;
    end else if ((cmd_inv ^ inv_mask_i) != cmd) begin
      status_o = ST_CMD_INV;
    end else begin
      status_o = ST_OK;
    end
  end

endmodule

/* rtl/ir_pulse_distance_frame_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder
// Pulse-distance IR remote frame decoder with programmable timing windows.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one transaction per falling
//   edge (action 0, interval = ticks since the previous edge) or an
//   end-of-frame timeout (action 1). The first edge arms the receiver, the
//   next interval is checked against the start window, the following 32 are
//   classified as zero or one bits, LSB first.
//   A timeout on an armed receiver emits one result transaction on the
//   output channel (status, address, command) and clears the receiver.
//   An item is registered at acceptance and evaluated from the input
//   register; a timeout's result then goes to the result register.
//   One item per cycle while the result side is not stalled; the input
//   register and the result register decouple the two sides, so one
//   more item is taken while a result waits.
//   When the receiver stalls, the pending item holds in the input register
//   and in_ready_o drops until the result is taken.
//   Reset clears the receiver and the channels; thresholds reset to zero and
//   the inversion mask to all ones. Write configuration only while idle.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder #(
  parameter int unsigned INTERVAL_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [INTERVAL_BITS-1:0]       interval_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ipd_pkg::STATUS_W-1:0]   status_o,
  output logic [ipd_pkg::BYTE_W-1:0]     address_o,
  output logic [ipd_pkg::BYTE_W-1:0]     command_o,
  input  logic                           cfg_we_i,
  input  logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ipd_pkg::CFG_W-1:0]      cfg_data_i
);
  import ipd_pkg::*;

  localparam int unsigned CmpW = (INTERVAL_BITS > CFG_W) ? INTERVAL_BITS : CFG_W;

  // configuration registers
  logic [CFG_W-1:0]  start_low_q, start_high_q;
  logic [CFG_W-1:0]  zero_low_q, zero_high_q;
  logic [CFG_W-1:0]  one_low_q, one_high_q;
  logic [BYTE_W-1:0] exp_addr_q, inv_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_low_q  <= '0;
      start_high_q <= '0;
      zero_low_q   <= '0;
      zero_high_q  <= '0;
      one_low_q    <= '0;
      one_high_q   <= '0;
      exp_addr_q   <= '0;
      inv_mask_q   <= INV_MASK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_LOW:  start_low_q  <= cfg_data_i;
        CFG_START_HIGH: start_high_q <= cfg_data_i;
        CFG_ZERO_LOW:   zero_low_q   <= cfg_data_i;
        CFG_ZERO_HIGH:  zero_high_q  <= cfg_data_i;
        CFG_ONE_LOW:    one_low_q    <= cfg_data_i;
        CFG_ONE_HIGH:   one_high_q   <= cfg_data_i;
        CFG_EXP_ADDR:   exp_addr_q   <= cfg_data_i[BYTE_W-1:0];
        CFG_INV_MASK:   inv_mask_q   <= cfg_data_i[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                     s1_valid_q;
  logic                     s1_action_q;
  logic [INTERVAL_BITS-1:0] s1_interval_q;
  logic                     advance;
  logic                     proc;

  logic out_valid_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign proc       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_action_q   <= action_i;
      s1_interval_q <= interval_i;
    end
  end

  // window compares
  logic [CmpW-1:0] ival;
  logic            in_start, in_zero, in_one;

  assign ival     = CmpW'(s1_interval_q);
  assign in_start = (ival >= CmpW'(start_low_q)) && (ival <= CmpW'(start_high_q));
  assign in_zero  = (ival >= CmpW'(zero_low_q))  && (ival <= CmpW'(zero_high_q));
  assign in_one   = (ival >= CmpW'(one_low_q))   && (ival <= CmpW'(one_high_q));

  // receiver state
  logic       armed_q, armed_d;
  ipd_frame_t frame_q, frame_d;
  logic       emit;
  logic [POS_W-1:0] pos;

  assign pos = POS_W'(frame_q.count - COUNT_W'(1));

  always_comb begin
    armed_d = armed_q;
    frame_d = frame_q;
    emit    = 1'b0;
    if (proc) begin
      if (s1_action_q == ACT_EDGE) begin
        if (!armed_q) begin
          armed_d = 1'b1;
        end else if (frame_q.count < FRAME_INTERVALS) begin
          if (frame_q.count == '0) begin
            frame_d.start_ok = in_start;
          end else if (in_zero) begin
            // zero bit: leave it clear
          end else if (in_one) begin
            frame_d.bits = frame_q.bits | (FRAME_W'(1) << pos);
          end else begin
            frame_d.bit_error = 1'b1;
          end
          frame_d.count = frame_q.count + COUNT_W'(1);
        end
      end else if (armed_q) begin
        // close the frame and clear, good or not
        emit    = 1'b1;
        armed_d = 1'b0;
        frame_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      frame_q <= '0;
    end else begin
      armed_q <= armed_d;
      frame_q <= frame_d;
    end
  end

  logic [STATUS_W-1:0] status;

  ipd_status u_status (
    .frame_i    (frame_q),
    .exp_addr_i (exp_addr_q),
    .inv_mask_i (inv_mask_q),
    .status_o   (status)
  );

  // result register
  logic [STATUS_W-1:0] status_q;
  logic [BYTE_W-1:0]   address_q, command_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q  <= status;
      address_q <= frame_q.bits[7:0];
      command_q <= (status == ST_OK) ? frame_q.bits[23:16] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign address_o   = address_q;
  assign command_o   = command_q;

endmodule

/* rtl/ipd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_checker
// Port-level checks of the IR frame decoder, attached to the top level.
// ----------------------------------------------------------------------------
module ipd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ipd_pkg::STATUS_W-1:0]  status_o,
  input logic [ipd_pkg::BYTE_W-1:0]    address_o,
  input logic [ipd_pkg::BYTE_W-1:0]    command_o
);
  import ipd_pkg::*;

  // a stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(address_o) && $stable(command_o))
    else $error("result changed while stalled");

  // an empty result register never blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with no pending result");

  // only the defined status codes appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 3'd7)
    else $error("undefined status code");

  // command is reported only for a good frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> command_o == '0)
    else $error("command reported on a failed frame");

endmodule

bind ir_pulse_distance_frame_decoder ipd_checker u_ipd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .address_o   (address_o),
  .command_o   (command_o)
);

/* tb/tb_ir_pulse_distance_frame_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ir_pulse_distance_frame_decoder
// Self-checking bench for the IR frame decoder. Random NEC-style frames are
// built from the programmed timing windows, some clean and some broken
// (short, bad start, bad bit, inversion and address errors, surplus edges,
// noise). They are sent over four timing setups with random back-pressure on
// both channels. A behavioral decoder predicts every frame report, and each
// report is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_ir_pulse_distance_frame_decoder;
  import ipd_pkg::*;

  localparam int unsigned IVAL_W        = 24;
  localparam int unsigned PAD_W         = CFG_W - BYTE_W;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   address;
    logic [BYTE_W-1:0]   command;
  } frame_report_t;

  typedef enum int unsigned {
    FLT_NONE,
    FLT_SHORT,
    FLT_BAD_START,
    FLT_BAD_BIT,
    FLT_ADDR_INV,
    FLT_ADDR_MISMATCH,
    FLT_CMD_INV,
    FLT_SURPLUS,
    FLT_NOISE
  } frame_fault_e;

  class frame_scoreboard;
    logic [CFG_W-1:0]   regs_q [8];
    logic               armed;
    logic [COUNT_W-1:0] n_ivals;
    logic               start_ok;
    logic               bit_err;
    logic [FRAME_W-1:0] bits;
    frame_report_t      expected_reports [$];
    int unsigned        items_used;
    int unsigned        reports_checked;
    int unsigned        mismatches;
    int unsigned        status_hits [8];

    function new();
      foreach (regs_q[i]) regs_q[i] = '0;
      regs_q[CFG_INV_MASK] = CFG_W'(INV_MASK_RESET);
      foreach (status_hits[i]) status_hits[i] = 0;
      items_used      = 0;
      reports_checked = 0;
      mismatches      = 0;
      clear_frame();
    endfunction

    static function bit in_window(logic [CFG_W-1:0] v, logic [CFG_W-1:0] lo,
                                  logic [CFG_W-1:0] hi);
      return v >= lo && v <= hi;
    endfunction

    function void clear_frame();
      armed    = 1'b0;
      n_ivals  = '0;
      start_ok = 1'b0;
      bit_err  = 1'b0;
      bits     = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_EXP_ADDR, CFG_INV_MASK: regs_q[idx] = CFG_W'(value[BYTE_W-1:0]);
        default: regs_q[idx] = value;
      endcase
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    // one accepted transaction on the input channel
    function void decode_item(logic act, logic [IVAL_W-1:0] ival);
      logic [POS_W-1:0]  pos;
      logic [BYTE_W-1:0] addr, addr_inv, cmd, cmd_inv, mask;
      frame_report_t     rpt;
      if (act == ACT_EDGE) begin
        if (!armed) begin
          armed = 1'b1;
          items_used++;
        end else if (n_ivals < FRAME_INTERVALS) begin
          if (n_ivals == '0) begin
            start_ok = in_window(ival, regs_q[CFG_START_LOW], regs_q[CFG_START_HIGH]);
          end else begin
            pos = POS_W'(n_ivals - 6'd1);
            // zero window wins where the two overlap
            if (!in_window(ival, regs_q[CFG_ZERO_LOW], regs_q[CFG_ZERO_HIGH])) begin
              if (in_window(ival, regs_q[CFG_ONE_LOW], regs_q[CFG_ONE_HIGH]))
                bits[pos] = 1'b1;
              else
                bit_err = 1'b1;
            end
          end
          n_ivals++;
          items_used++;
        end
      end else if (armed) begin
        addr     = bits[7:0];
        addr_inv = bits[15:8];
        cmd      = bits[23:16];
        cmd_inv  = bits[31:24];
        mask     = regs_q[CFG_INV_MASK][BYTE_W-1:0];
        if (n_ivals < FRAME_INTERVALS)                    rpt.status = ST_INCOMPLETE;
        else if (!start_ok)                               rpt.status = ST_BAD_START;
        else if (bit_err)                                 rpt.status = ST_BAD_BIT;
        else if ((addr_inv ^ mask) != addr)               rpt.status = ST_ADDR_INV;
        else if (addr != regs_q[CFG_EXP_ADDR][BYTE_W-1:0]) rpt.status = ST_ADDR_MISMATCH;
        else if ((cmd_inv ^ mask) != cmd)                 rpt.status = ST_CMD_INV;
        else                                              rpt.status = ST_OK;
        rpt.address = addr;
        rpt.command = (rpt.status == ST_OK) ? cmd : '0;
        expected_reports.push_back(rpt);
        clear_frame();
        items_used++;
      end
    endfunction

    function void check_report(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] addr,
                               logic [BYTE_W-1:0] cmd);
      frame_report_t want;
      reports_checked++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] unexpected frame report: status %0d address %02h command %02h",
                   $time, st, addr, cmd);
      end else begin
        want = expected_reports.pop_front();
        status_hits[want.status]++;
        if (st !== want.status || addr !== want.address || cmd !== want.command) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display({"[%0t] frame report mismatch: expected status %0d address %02h ",
                      "command %02h, got status %0d address %02h command %02h"},
                     $time, want.status, want.address, want.command, st, addr, cmd);
        end
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 action    = ACT_EDGE;
  logic [IVAL_W-1:0]    interval  = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [BYTE_W-1:0]    address;
  logic [BYTE_W-1:0]    command;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_START_LOW;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold     = 0;
  int unsigned quiet_cycles  = 0;

  frame_scoreboard frame_sb = new();

  ir_pulse_distance_frame_decoder #(
    .INTERVAL_BITS(IVAL_W)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .action_i   (action),
    .interval_i (interval),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .status_o   (status),
    .address_o  (address),
    .command_o  (command),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (recv_hold != 0) begin
        out_ready <= 1'b0;
        recv_hold--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) frame_sb.decode_item(action, interval);
      if (out_valid && out_ready) frame_sb.check_report(status, address, command);
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("ir_pulse_distance_frame_decoder regression: fail");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  function automatic logic [IVAL_W-1:0] pick_inside(logic [CFG_W-1:0] lo,
                                                    logic [CFG_W-1:0] hi);
    int unsigned span;
    if (lo > hi) return IVAL_W'($urandom);
    span = 32'(hi) - 32'(lo) + 32'd1;
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return lo + IVAL_W'($urandom % span);
    endcase
  endfunction

  // aim just past a window edge or anywhere at random, retrying to land outside both windows
  function automatic logic [IVAL_W-1:0] pick_outside(logic [CFG_W-1:0] lo0,
                                                     logic [CFG_W-1:0] hi0,
                                                     logic [CFG_W-1:0] lo1,
                                                     logic [CFG_W-1:0] hi1);
    logic [IVAL_W-1:0] v;
    v = '0;
    for (int k = 0; k < 16; k++) begin
      case ($urandom_range(4))
        0: v = lo0 - 1'b1;
        1: v = hi0 + 1'b1;
        2: v = lo1 - 1'b1;
        3: v = hi1 + 1'b1;
        default: v = IVAL_W'($urandom);
      endcase
      if (!frame_scoreboard::in_window(v, lo0, hi0) &&
          !frame_scoreboard::in_window(v, lo1, hi1))
        return v;
    end
    return v;
  endfunction

  task automatic send_item(input logic act, input logic [IVAL_W-1:0] ival);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    interval <= ival;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid and hold until every report is in and the pipeline is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    frame_sb.write_reg(idx, value);
  endtask

  task automatic load_config(input logic [CFG_W-1:0] s_lo, s_hi, z_lo, z_hi, o_lo, o_hi,
                             input logic [BYTE_W-1:0] exp_addr, mask);
    wait_drained();
    write_reg(CFG_START_LOW, s_lo);
    write_reg(CFG_START_HIGH, s_hi);
    write_reg(CFG_ZERO_LOW, z_lo);
    write_reg(CFG_ZERO_HIGH, z_hi);
    write_reg(CFG_ONE_LOW, o_lo);
    write_reg(CFG_ONE_HIGH, o_hi);
    // junk in the upper bits must be dropped for the byte registers
    write_reg(CFG_EXP_ADDR, {PAD_W'($urandom), exp_addr});
    write_reg(CFG_INV_MASK, {PAD_W'($urandom), mask});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame();
    frame_fault_e       fault;
    int unsigned        roll, n_bits, bad_pos;
    logic [FRAME_W-1:0] data;
    logic [BYTE_W-1:0]  addr, cmd, mask, exp_addr;
    logic [CFG_W-1:0]   s_lo, s_hi, z_lo, z_hi, o_lo, o_hi;
    logic [IVAL_W-1:0]  ival;
    s_lo     = frame_sb.regs_q[CFG_START_LOW];
    s_hi     = frame_sb.regs_q[CFG_START_HIGH];
    z_lo     = frame_sb.regs_q[CFG_ZERO_LOW];
    z_hi     = frame_sb.regs_q[CFG_ZERO_HIGH];
    o_lo     = frame_sb.regs_q[CFG_ONE_LOW];
    o_hi     = frame_sb.regs_q[CFG_ONE_HIGH];
    exp_addr = frame_sb.regs_q[CFG_EXP_ADDR][BYTE_W-1:0];
    mask     = frame_sb.regs_q[CFG_INV_MASK][BYTE_W-1:0];
    roll = $urandom_range(99);
    if (roll < 25)      fault = FLT_NONE;
    else if (roll < 37) fault = FLT_SHORT;
    else if (roll < 45) fault = FLT_BAD_START;
    else if (roll < 55) fault = FLT_BAD_BIT;
    else if (roll < 63) fault = FLT_ADDR_INV;
    else if (roll < 71) fault = FLT_ADDR_MISMATCH;
    else if (roll < 79) fault = FLT_CMD_INV;
    else if (roll < 87) fault = FLT_SURPLUS;
    else                fault = FLT_NOISE;

    if (fault == FLT_NOISE) begin
      repeat ($urandom_range(1, 6)) send_item(logic'($urandom_range(1)), IVAL_W'($urandom));
      return;
    end

    if (fault == FLT_ADDR_MISMATCH)
      addr = exp_addr ^ (8'd1 << $urandom_range(7));
    else if ($urandom_range(3) == 0)
      addr = BYTE_W'($urandom);
    else
      addr = exp_addr;
    cmd  = BYTE_W'($urandom);
    data = {cmd ^ mask, cmd, addr ^ mask, addr};
    if (fault == FLT_ADDR_INV) data ^= FRAME_W'(1) << (8 + $urandom_range(7));
    if (fault == FLT_CMD_INV)  data ^= FRAME_W'(1) << (24 + $urandom_range(7));

    if (fault == FLT_SHORT)
      n_bits = ($urandom_range(3) == 0) ? $urandom_range(FRAME_W - 1) : $urandom_range(6);
    else
      n_bits = FRAME_W;
    bad_pos = $urandom_range(FRAME_W - 1);

    send_item(ACT_EDGE, IVAL_W'($urandom));
    send_item(ACT_EDGE, (fault == FLT_BAD_START) ? pick_outside(s_lo, s_hi, s_lo, s_hi)
                                                 : pick_inside(s_lo, s_hi));
    for (int b = 0; b < n_bits; b++) begin
      if (fault == FLT_BAD_BIT && b == bad_pos) ival = pick_outside(z_lo, z_hi, o_lo, o_hi);
      else if (data[b])                         ival = pick_inside(o_lo, o_hi);
      else                                      ival = pick_inside(z_lo, z_hi);
      send_item(ACT_EDGE, ival);
    end
    if (fault == FLT_SURPLUS)
      repeat ($urandom_range(1, 3)) send_item(ACT_EDGE, IVAL_W'($urandom));
    send_item(ACT_TIMEOUT, IVAL_W'($urandom));
  endtask

  task automatic run_phase(input int unsigned item_goal, input int unsigned report_goal);
    int unsigned items0, reports0;
    items0   = frame_sb.items_used;
    reports0 = frame_sb.reports_checked;
    while (frame_sb.items_used - items0 < item_goal ||
           frame_sb.reports_checked - reports0 < report_goal)
      send_frame();
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset windows are all [0,0], so 0 is both a start and a zero bit
    send_item(ACT_TIMEOUT, 24'hFFFFFF);
    send_item(ACT_EDGE, 24'hFFFFFF);
    send_item(ACT_EDGE, 24'h000000);
    send_item(ACT_EDGE, 24'h000000);
    send_item(ACT_EDGE, 24'hFFFFFF);
    send_item(ACT_TIMEOUT, 24'h000000);

    load_config(24'd13000, 24'd14000, 24'd1000, 24'd1300, 24'd2100, 24'd2400,
                BYTE_W'($urandom), 8'hFF);
    send_item(ACT_EDGE, 24'h000000);
    send_item(ACT_TIMEOUT, 24'hFFFFFF);
    send_item(ACT_EDGE, 24'h5A5A5A);
    send_item(ACT_EDGE, 24'hFFFFFF);
    send_item(ACT_EDGE, 24'd1000);
    send_item(ACT_EDGE, 24'd2400);
    send_item(ACT_TIMEOUT, 24'hA5A5A5);

    send_idle_pct = 15;
    recv_idle_pct = 54;
    run_phase(80, 3);
    // stall the result side long enough to back up the input channel
    recv_hold = HOLD_CYCLES;
    repeat (6) begin
      send_item(ACT_EDGE, IVAL_W'($urandom));
      send_item(ACT_TIMEOUT, IVAL_W'($urandom));
    end
    send_frame();
    wait_drained();
    run_phase(80, 3);

    load_config(24'h000000, 24'hFFFFFF, 24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
                8'hFF, 8'h00);
    send_idle_pct = 54;
    recv_idle_pct = 15;
    run_phase(100, 3);

    load_config(24'd9000, 24'd9000, 24'd1000, 24'd2000, 24'd1500, 24'd2500,
                BYTE_W'($urandom), BYTE_W'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(90, 3);

    // the one window inverted, the zero window a single top value, the start window a single zero value
    load_config(24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000,
                8'h00, BYTE_W'($urandom));
    run_phase(50, 2);

    wait_drained();
    $display("Covered %0d decoder items over four timing setups, with stalls on both sides",
             frame_sb.items_used);
    $display({"Frame reports: %0d (ok %0d, incomplete %0d, bad start %0d, bad bit %0d, ",
              "addr inversion %0d, addr mismatch %0d, cmd inversion %0d)"},
             frame_sb.reports_checked, frame_sb.status_hits[ST_OK],
             frame_sb.status_hits[ST_INCOMPLETE], frame_sb.status_hits[ST_BAD_START],
             frame_sb.status_hits[ST_BAD_BIT], frame_sb.status_hits[ST_ADDR_INV],
             frame_sb.status_hits[ST_ADDR_MISMATCH], frame_sb.status_hits[ST_CMD_INV]);
    if (frame_sb.mismatches == 0 && frame_sb.pending() == 0) begin
      $display("ir_pulse_distance_frame_decoder regression: pass");
    end else begin
      $display("%0d mismatches, %0d reports never arrived",
               frame_sb.mismatches, frame_sb.pending());
      $display("ir_pulse_distance_frame_decoder regression: fail");
    end
    $finish;
  end

endmodule
